>>> rtl/core/tcpck_pkg.sv
package tcpck_pkg;

   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [3:0]  MinWords      = 4'd5;
   localparam logic [15:0] LenFieldHi    = 16'd2;
   localparam logic [15:0] LenFieldLo    = 16'd3;
   localparam logic [15:0] FixedHdrBytes = 16'd4;
   localparam logic [15:0] OffsetByte    = 16'd12;
   localparam logic [15:0] PseudoFirst   = 16'd12;
   localparam logic [15:0] PseudoEnd     = 16'd20;
   localparam logic [15:0] IndexMax      = 16'hffff;

   typedef struct packed {
      logic [15:0] idx;
      logic [15:0] hdr_sum;
      logic [15:0] seg_sum;
      logic [7:0]  pend;
      logic [3:0]  hdr_words;
      logic [15:0] total_len;
      logic [3:0]  seg_offset;
   } snap_type;

   // end-around carry add; one fold is enough for two 16-bit operands
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   function automatic logic in_pseudo(input logic [15:0] idx);
      return (idx >= PseudoFirst) && (idx < PseudoEnd);
   endfunction

endpackage

>>> rtl/core/tcpck_accum.sv
module tcpck_accum
   import tcpck_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       snap_valid,
   input  logic       snap_ready,
   output snap_type   snap
);

   logic        in_v_ff, in_v_in;
   logic [7:0]  byte_ff;
   logic        last_ff;

   logic [15:0] idx_ff, idx_in;
   logic [15:0] hs_ff, hs_in;
   logic [15:0] ss_ff, ss_in;
   logic [3:0]  hw_ff, hw_in;
   logic [15:0] tl_ff, tl_in;
   logic [3:0]  so_ff, so_in;
   logic [7:0]  pend_ff, pend_in;

   logic        snap_v_ff, snap_v_in;
   snap_type    snap_ff, snap_in;

   logic        s1_fire, snap_free, accept;
   logic [3:0]  hw_n;
   logic [15:0] hl16, tl_n, w, seg_a;
   logic        counted, in_hdr;

   assign snap_free  = !snap_v_ff || snap_ready;
   assign s1_fire    = in_v_ff && (!last_ff || snap_free);
   assign req_ready  = !in_v_ff || s1_fire;
   assign accept     = req_valid && req_ready;
   assign snap_valid = snap_v_ff;
   assign snap       = snap_ff;

   always_comb begin
      hw_n = (idx_ff == '0) ? byte_ff[3:0] : hw_ff;
      hl16 = {10'b0, hw_n, 2'b00};
      tl_n = tl_ff;
      if (idx_ff == LenFieldHi) begin
         tl_n = {byte_ff, tl_ff[7:0]};
      end
      if (idx_ff == LenFieldLo) begin
         tl_n = {tl_ff[15:8], byte_ff};
      end
      counted = (idx_ff < FixedHdrBytes) || (idx_ff < tl_n);
      in_hdr  = idx_ff < hl16;
      w       = {pend_ff, byte_ff};

      so_in   = so_ff;
      pend_in = pend_ff;
      hs_in   = hs_ff;
      ss_in   = ss_ff;
      seg_a   = in_hdr ? ss_ff : oc_add(ss_ff, w);
      if (counted) begin
         if (!in_hdr && (idx_ff == hl16 + OffsetByte)) begin
            so_in = byte_ff[7:4];
         end
         if (!idx_ff[0]) begin
            pend_in = byte_ff;
         end else begin
            hs_in = in_hdr ? oc_add(hs_ff, w) : hs_ff;
            ss_in = in_pseudo(idx_ff) ? oc_add(seg_a, w) : seg_a;
         end
      end
      hw_in  = hw_n;
      tl_in  = tl_n;
      idx_in = (idx_ff == IndexMax) ? idx_ff : idx_ff + 16'd1;

      snap_in.idx        = idx_ff;
      snap_in.hdr_sum    = hs_in;
      snap_in.seg_sum    = ss_in;
      snap_in.pend       = pend_in;
      snap_in.hdr_words  = hw_in;
      snap_in.total_len  = tl_in;
      snap_in.seg_offset = so_in;

      if (accept) begin
         in_v_in = 1'b1;
      end else if (s1_fire) begin
         in_v_in = 1'b0;
      end else begin
         in_v_in = in_v_ff;
      end

      if (s1_fire && last_ff) begin
         snap_v_in = 1'b1;
      end else if (snap_ready) begin
         snap_v_in = 1'b0;
      end else begin
         snap_v_in = snap_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (s1_fire && last_ff) begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         snap_v_ff <= 1'b0;
         idx_ff    <= '0;
         hs_ff     <= '0;
         ss_ff     <= '0;
         hw_ff     <= '0;
         tl_ff     <= '0;
         so_ff     <= '0;
         pend_ff   <= '0;
      end else begin
         in_v_ff   <= in_v_in;
         snap_v_ff <= snap_v_in;
         if (s1_fire) begin
            if (last_ff) begin
               idx_ff  <= '0;
               hs_ff   <= '0;
               ss_ff   <= '0;
               hw_ff   <= '0;
               tl_ff   <= '0;
               so_ff   <= '0;
               pend_ff <= '0;
            end else begin
               idx_ff  <= idx_in;
               hs_ff   <= hs_in;
               ss_ff   <= ss_in;
               hw_ff   <= hw_in;
               tl_ff   <= tl_in;
               so_ff   <= so_in;
               pend_ff <= pend_in;
            end
         end
      end
   end

endmodule

>>> rtl/core/tcpck_finish.sv
module tcpck_finish
   import tcpck_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        snap_valid,
   output logic        snap_ready,
   input  snap_type    snap,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_ip_checksum,
   output logic [15:0] rsp_tcp_checksum,
   output logic        rsp_length_error
);

   logic        out_v_ff, out_v_in;
   logic [15:0] ip_ff, ip_in;
   logic [15:0] tcp_ff, tcp_in;
   logic        err_ff, err_in;

   logic [16:0] received, count, last_idx, tl17;
   logic [15:0] hl16, pad_w, hs_p, ss_a, ss_b, ss_c, ss_d, tcp_len, seg_bytes;
   logic        odd, pad_hdr, len_short;

   assign snap_ready       = !out_v_ff || rsp_ready;
   assign rsp_valid        = out_v_ff;
   assign rsp_ip_checksum  = ip_ff;
   assign rsp_tcp_checksum = tcp_ff;
   assign rsp_length_error = err_ff;

   always_comb begin
      hl16     = {10'b0, snap.hdr_words, 2'b00};
      tl17     = {1'b0, snap.total_len};
      received = {1'b0, snap.idx} + 17'd1;
      count    = ((snap.idx < FixedHdrBytes) || (received <= tl17)) ? received : tl17;
      odd      = count[0];
      last_idx = count - 17'd1;
      pad_hdr  = last_idx < {1'b0, hl16};
      pad_w    = {snap.pend, 8'h00};

      hs_p = (odd && pad_hdr) ? oc_add(snap.hdr_sum, pad_w) : snap.hdr_sum;
      ss_a = (odd && !pad_hdr) ? oc_add(snap.seg_sum, pad_w) : snap.seg_sum;
      ss_b = (odd && in_pseudo(last_idx[15:0])) ? oc_add(ss_a, pad_w) : ss_a;
      ss_c = oc_add(ss_b, {8'b0, ProtoTcp});
      tcp_len = snap.total_len - hl16;
      ss_d = oc_add(ss_c, tcp_len);

      len_short = snap.total_len < hl16;
      seg_bytes = {10'b0, snap.seg_offset, 2'b00};
      err_in = (received < tl17) || (snap.hdr_words < MinWords) || len_short ||
               (!len_short && ((snap.seg_offset < MinWords) || (seg_bytes > tcp_len)));
      ip_in  = ~hs_p;
      tcp_in = ~ss_d;

      if (snap_valid && snap_ready) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         ip_ff  <= ip_in;
         tcp_ff <= tcp_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

endmodule

>>> rtl/core/ipv4_tcp_checksum_engine_top.sv
// A last byte's result passes the input, snapshot and output registers.
// Throughput: one byte per cycle, one sum update each, unless a last byte waits.
// A byte is taken while a finished result still waits in the output register.
// Reset: synchronous, active high; clears all sums, counters and valid flags.
module ipv4_tcp_checksum_engine_top
   import tcpck_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_ip_checksum,
   output logic [15:0] rsp_tcp_checksum,
   output logic        rsp_length_error
);

   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   tcpck_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap)
   );

   tcpck_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .snap_valid       (snap_valid),
      .snap_ready       (snap_ready),
      .snap             (snap),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ip_checksum  (rsp_ip_checksum),
      .rsp_tcp_checksum (rsp_tcp_checksum),
      .rsp_length_error (rsp_length_error)
   );

endmodule

>>> rtl/core/tcpck_checker.sv
module tcpck_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_ip_checksum,
   input logic [15:0] rsp_tcp_checksum,
   input logic        rsp_length_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ip_checksum) &&
      $stable(rsp_tcp_checksum) && $stable(rsp_length_error))
      else $error("result word changed while stalled");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled with output free");

endmodule

bind ipv4_tcp_checksum_engine_top tcpck_checker u_tcpck_checker (.*);
